[design/vnth_pkg.sv]
`default_nettype none

package vnth_pkg;

    // height field and configuration port sizes
    localparam int HEIGHT_W   = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    // register index, taken from the upper address bit (8-byte spacing)
    localparam logic REG_SEED = 1'b0;

    // corner hash constants
    localparam logic [31:0] HASH_MUL_X = 32'h8da6b343;
    localparam logic [31:0] HASH_MUL_Z = 32'hd8163841;
    localparam logic [31:0] SEED_MUL   = 32'hcb1ab31f;
    localparam logic [31:0] MIX_MUL_A  = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL_B  = 32'h846ca68b;

    // per-octave salts
    localparam logic [31:0] SALT_CELL48 = 32'h6d2b79f5;
    localparam logic [31:0] SALT_CELL18 = 32'h1b56c4e9;
    localparam logic [31:0] SALT_CELL7  = 32'ha511e9b3;
    localparam logic [31:0] SALT_CELL64 = 32'h04f1bbcd;

    // register stages in each octave lane and in the final combine
    localparam int OCT_STAGES  = 10;
    localparam int COMB_STAGES = 3;
    localparam int PIPE_DEPTH  = OCT_STAGES + COMB_STAGES;

endpackage

`default_nettype wire

[design/vnth_octave.sv]
`default_nettype none

module vnth_octave
    import vnth_pkg::*;
#(
    parameter int          CELL          = 48,
    parameter logic [31:0] SALT          = 32'h0,
    parameter int          FRACTION_BITS = 16,
    parameter int          COLUMN_BITS   = 20
)
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [COLUMN_BITS-1:0]     x,
    input  wire logic [COLUMN_BITS-1:0]     z,
    input  wire logic [31:0]                seed_mix,
    output logic signed [FRACTION_BITS+1:0] oct
);

    localparam int F   = FRACTION_BITS;
    localparam int N   = COLUMN_BITS;
    localparam int L   = $clog2(CELL);
    localparam int SH  = N + L;
    localparam int MW  = N + 1;
    localparam int PW  = N + MW;
    localparam int CW  = F + 2;
    localparam int DW  = F + 3;
    localparam int PRW = DW + F + 2;
    localparam int SW  = (F + 3 > 17) ? F + 3 : 17;
    localparam longint ONE  = longint'(1) << F;
    localparam longint HALF = longint'(1) << (F - 1);
    localparam logic [MW-1:0] RECIP = MW'(((longint'(1) << SH) + CELL - 1) / CELL);

    typedef logic [F:0] ease_tab_t [CELL];

    // smoothstep weight for every remainder, worked out at elaboration
    function automatic ease_tab_t ease_table();
        ease_tab_t tab;
        longint    t;
        longint    t2;
        for (int i = 0; i < CELL; i++)
        begin
            t      = (longint'(i) * 2 * ONE + CELL) / (2 * CELL);
            t2     = (t * t + HALF) >>> F;
            tab[i] = (F + 1)'((t2 * (3 * ONE - 2 * t) + HALF) >>> F);
        end
        return tab;
    endfunction

    localparam ease_tab_t EASE_TAB = ease_table();

    // stage 1: reciprocal multiply for the lattice index
    logic [PW-1:0] px_reg, pz_reg;
    logic [N-1:0]  x1_reg, z1_reg;
    // stage 2: lattice index and remainder
    logic [N-1:0]  x0_next, z0_next, x0_reg, z0_reg;
    logic [L-1:0]  rx_next, rz_next, rx_reg, rz_reg;
    // stage 3: weights and coordinate products
    logic [31:0]   mx0_reg, mx1_reg, mz0_reg, mz1_reg;
    logic [F:0]    wx_line_reg [4];
    logic [F:0]    wz_line_reg [6];
    // stages 4 to 6: hash rounds and corner values
    logic [31:0]   pre_next [4];
    logic [31:0]   v1_reg   [4];
    logic [31:0]   v2_reg   [4];
    logic [31:0]   v3_next  [4];
    logic [F+17:0] cn_next  [4];
    logic [F+1:0]  ca_next  [4];
    logic [SW-1:0] cs1_next [4];
    logic [16:0]   cs2_next [4];
    logic [F+1:0]  cq_next  [4];
    logic signed [CW-1:0] cval_reg [4];
    // stages 7 to 10: blends along x then z
    logic signed [DW-1:0]  d0_next, d1_next, d2_next;
    logic signed [PRW-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [PRW-1:0] p0_rnd, p1_rnd, p2_rnd;
    logic signed [CW-1:0]  c0_reg, c2_reg, r0_reg, r1_reg, r0b_reg;
    logic signed [CW-1:0]  oct_reg;

    // lattice index by reciprocal, remainder by back multiply
    always_comb
    begin
        x0_next = N'(px_reg >> SH);
        z0_next = N'(pz_reg >> SH);
        rx_next = L'(x1_reg - N'(x0_next * N'(CELL)));
        rz_next = L'(z1_reg - N'(z0_next * N'(CELL)));
    end

    // corner hash rounds and the map of the low hash bits onto -one..one
    always_comb
    begin
        pre_next[0] = mx0_reg ^ mz0_reg ^ seed_mix ^ SALT;
        pre_next[1] = mx1_reg ^ mz0_reg ^ seed_mix ^ SALT;
        pre_next[2] = mx0_reg ^ mz1_reg ^ seed_mix ^ SALT;
        pre_next[3] = mx1_reg ^ mz1_reg ^ seed_mix ^ SALT;
        for (int i = 0; i < 4; i++)
        begin
            pre_next[i] = pre_next[i] ^ (pre_next[i] >> 16);
            v3_next[i]  = v2_reg[i] ^ (v2_reg[i] >> 16);
            // divide by 65535 as folded 16-bit digits plus one correction
            cn_next[i]  = (F + 18)'({v3_next[i][15:0], {(F + 1){1'b0}}})
                        + (F + 18)'(32767);
            ca_next[i]  = cn_next[i][F+17:16];
            cs1_next[i] = SW'(ca_next[i]) + SW'(cn_next[i][15:0]);
            cs2_next[i] = 17'(cs1_next[i][SW-1:16]) + 17'(cs1_next[i][15:0]);
            cq_next[i]  = ca_next[i] + (F + 2)'(cs1_next[i][SW-1:16])
                        + (F + 2)'(cs2_next[i] >= 17'd65535);
        end
    end

    // blend differences and rounding of the products
    always_comb
    begin
        d0_next = DW'(cval_reg[1]) - DW'(cval_reg[0]);
        d1_next = DW'(cval_reg[3]) - DW'(cval_reg[2]);
        d2_next = DW'(r1_reg) - DW'(r0_reg);
        p0_rnd  = (p0_reg + PRW'(HALF)) >>> F;
        p1_rnd  = (p1_reg + PRW'(HALF)) >>> F;
        p2_rnd  = (p2_reg + PRW'(HALF)) >>> F;
    end

    // lane registers, all advancing together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= PW'(x) * PW'(RECIP);
            pz_reg  <= PW'(z) * PW'(RECIP);
            x1_reg  <= x;
            z1_reg  <= z;

            x0_reg  <= x0_next;
            z0_reg  <= z0_next;
            rx_reg  <= rx_next;
            rz_reg  <= rz_next;

            mx0_reg <= 32'(x0_reg) * HASH_MUL_X;
            mx1_reg <= (32'(x0_reg) + 32'd1) * HASH_MUL_X;
            mz0_reg <= 32'(z0_reg) * HASH_MUL_Z;
            mz1_reg <= (32'(z0_reg) + 32'd1) * HASH_MUL_Z;
            wx_line_reg[0] <= EASE_TAB[rx_reg];
            wz_line_reg[0] <= EASE_TAB[rz_reg];
            for (int i = 1; i < 4; i++)
            begin
                wx_line_reg[i] <= wx_line_reg[i-1];
            end
            for (int i = 1; i < 6; i++)
            begin
                wz_line_reg[i] <= wz_line_reg[i-1];
            end

            for (int i = 0; i < 4; i++)
            begin
                v1_reg[i]   <= pre_next[i] * MIX_MUL_A;
                v2_reg[i]   <= (v1_reg[i] ^ (v1_reg[i] >> 15)) * MIX_MUL_B;
                cval_reg[i] <= $signed(cq_next[i] - (F + 2)'(ONE));
            end

            p0_reg  <= d0_next * $signed({1'b0, wx_line_reg[3]});
            p1_reg  <= d1_next * $signed({1'b0, wx_line_reg[3]});
            c0_reg  <= cval_reg[0];
            c2_reg  <= cval_reg[2];

            r0_reg  <= c0_reg + CW'(p0_rnd);
            r1_reg  <= c2_reg + CW'(p1_rnd);

            p2_reg  <= d2_next * $signed({1'b0, wz_line_reg[5]});
            r0b_reg <= r0_reg;

            oct_reg <= r0b_reg + CW'(p2_rnd);
        end
    end

    assign oct = oct_reg;

endmodule

`default_nettype wire

[design/vnth_combine.sv]
`default_nettype none

module vnth_combine
    import vnth_pkg::*;
#(
    parameter int HEIGHT_CAP    = 30,
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [FRACTION_BITS+1:0] oct48,
    input  wire logic signed [FRACTION_BITS+1:0] oct18,
    input  wire logic signed [FRACTION_BITS+1:0] oct7,
    input  wire logic signed [FRACTION_BITS+1:0] oct64,
    output logic [HEIGHT_W-1:0]                height
);

    localparam int F   = FRACTION_BITS;
    localparam int HW  = F + 7;
    localparam int PRW = HW + F + 3;
    localparam longint ONE  = longint'(1) << F;
    localparam longint HALF = longint'(1) << (F - 1);
    localparam logic signed [HW-1:0] BASE   = HW'(12 * ONE);
    localparam logic signed [HW-1:0] P_HI   = HW'((68 * ONE + 50) / 100);
    localparam logic signed [HW-1:0] P_LO   = -HW'((72 * ONE + 50) / 100);
    localparam logic signed [HW-1:0] TGT_HI = HW'(22 * ONE);
    localparam logic signed [HW-1:0] TGT_LO = HW'(5 * ONE);
    localparam logic signed [HW-1:0] W_MAX  = HW'(ONE);
    localparam logic signed [9:0]    CAP_Q  = 10'(HEIGHT_CAP);
    localparam logic signed [9:0]    MIN_Q  = 10'sd2;

    logic signed [HW-1:0]  e48, e18, e7, p;
    logic signed [HW-1:0]  h_next, wt_next, tgt_next;
    logic [F:0]            w_next;
    logic signed [HW-1:0]  h_reg, tgt_reg, h2_reg;
    logic [F:0]            w_reg;
    logic signed [HW:0]    dd;
    logic signed [PRW-1:0] prod_reg, prod_rnd;
    logic signed [HW-1:0]  hf, qs;
    logic signed [9:0]     q;
    logic [9:0]            qc;
    logic [HEIGHT_W-1:0]   height_reg;

    // weighted octave sum and the pull toward the plateau or the basin
    always_comb
    begin
        e48     = HW'(oct48);
        e18     = HW'(oct18);
        e7      = HW'(oct7);
        p       = HW'(oct64);
        h_next  = BASE + (e48 <<< 3) + (e18 <<< 2) + ((e7 + (e7 <<< 1) + HW'(1)) >>> 1);
        wt_next  = '0;
        tgt_next = '0;
        if (p > P_HI)
        begin
            wt_next  = ((p - P_HI) + ((p - P_HI) <<< 2) + HW'(1)) >>> 1;
            tgt_next = TGT_HI;
        end
        else if (p < P_LO)
        begin
            wt_next  = (P_LO - p) <<< 1;
            tgt_next = TGT_LO;
        end
        if (wt_next > W_MAX)
        begin
            wt_next = W_MAX;
        end
        w_next = (F + 1)'(wt_next);
    end

    // final blend, rounding and clamp
    always_comb
    begin
        dd       = (HW + 1)'(tgt_reg) - (HW + 1)'(h_reg);
        prod_rnd = (prod_reg + PRW'(HALF)) >>> F;
        hf       = h2_reg + HW'(prod_rnd);
        qs       = (hf + HW'(HALF)) >>> F;
        q        = 10'(qs);
        if (q > CAP_Q)
        begin
            qc = CAP_Q;
        end
        else if (q < MIN_Q)
        begin
            qc = MIN_Q;
        end
        else
        begin
            qc = q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg      <= h_next;
            w_reg      <= w_next;
            tgt_reg    <= tgt_next;
            prod_reg   <= dd * $signed({1'b0, w_reg});
            h2_reg     <= h_reg;
            height_reg <= qc[HEIGHT_W-1:0];
        end
    end

    assign height = height_reg;

endmodule

`default_nettype wire

[design/value_noise_terrain_height_unit.sv]
`default_nettype none

// Terrain height unit: one column coordinate pair in, one height out. Four
// value-noise octaves (cells 48, 18, 7 and 64) run as parallel lanes of ten
// register stages each, followed by three stages that weight, blend toward
// the plateau or basin level, round and clamp to 2..HEIGHT_CAP. A new column
// is taken every cycle while in_stall is low; results leave through an output
// register with one skid entry. The seed register sits at byte address 0 and is
// 64 bits wide; write it only while no column is in flight.

module value_noise_terrain_height_unit
    import vnth_pkg::*;
#(
    parameter int HEIGHT_CAP    = 30,
    parameter int FRACTION_BITS = 16,
    parameter int COLUMN_BITS   = 20
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [COLUMN_BITS-1:0] coord_x,
    input  wire logic [COLUMN_BITS-1:0] coord_z,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [HEIGHT_W-1:0]         height
);

    localparam int CW = FRACTION_BITS + 2;

    logic [CFG_DATA_W-1:0] seed_reg;
    logic [31:0]           seed_mix_reg;
    logic                  cfg_write;
    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  skid_full_reg, out_valid_reg;
    logic [HEIGHT_W-1:0]   skid_data_reg, out_data_reg;
    logic [HEIGHT_W-1:0]   pipe_height;
    logic signed [CW-1:0]  o48, o18, o7, o64;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_SEED);
    assign prdata    = (paddr[CFG_ADDR_W-1] == REG_SEED) ? seed_reg : '0;

    // seed and its folded 32-bit form used by every corner hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= '0;
            seed_mix_reg <= '0;
        end
        else if (cfg_write)
        begin
            seed_reg     <= pwdata;
            seed_mix_reg <= pwdata[31:0] ^ (pwdata[63:32] * SEED_MUL);
        end
    end

    // the pipeline moves unless the skid register already holds a result
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    vnth_octave #(
        .CELL(48), .SALT(SALT_CELL48),
        .FRACTION_BITS(FRACTION_BITS), .COLUMN_BITS(COLUMN_BITS)
    ) u_oct48 (
        .clk(clk), .en(en), .x(coord_x), .z(coord_z),
        .seed_mix(seed_mix_reg), .oct(o48)
    );

    vnth_octave #(
        .CELL(18), .SALT(SALT_CELL18),
        .FRACTION_BITS(FRACTION_BITS), .COLUMN_BITS(COLUMN_BITS)
    ) u_oct18 (
        .clk(clk), .en(en), .x(coord_x), .z(coord_z),
        .seed_mix(seed_mix_reg), .oct(o18)
    );

    vnth_octave #(
        .CELL(7), .SALT(SALT_CELL7),
        .FRACTION_BITS(FRACTION_BITS), .COLUMN_BITS(COLUMN_BITS)
    ) u_oct7 (
        .clk(clk), .en(en), .x(coord_x), .z(coord_z),
        .seed_mix(seed_mix_reg), .oct(o7)
    );

    vnth_octave #(
        .CELL(64), .SALT(SALT_CELL64),
        .FRACTION_BITS(FRACTION_BITS), .COLUMN_BITS(COLUMN_BITS)
    ) u_oct64 (
        .clk(clk), .en(en), .x(coord_x), .z(coord_z),
        .seed_mix(seed_mix_reg), .oct(o64)
    );

    vnth_combine #(
        .HEIGHT_CAP(HEIGHT_CAP), .FRACTION_BITS(FRACTION_BITS)
    ) u_combine (
        .clk(clk), .en(en),
        .oct48(o48), .oct18(o18), .oct7(o7), .oct64(o64),
        .height(pipe_height)
    );

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (en)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_full_reg <= valid_reg[PIPE_DEPTH-1];
            end
            else
            begin
                out_valid_reg <= valid_reg[PIPE_DEPTH-1];
            end
        end
        else if (!out_stall)
        begin
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (out_valid_reg && out_stall)
            begin
                skid_data_reg <= pipe_height;
            end
            else
            begin
                out_data_reg <= pipe_height;
            end
        end
        else if (!out_stall)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = out_data_reg;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

module tb_top;
    import vnth_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEIGHT_CAP    = 30;
    localparam int FRACTION_BITS = 16;
    localparam int COLUMN_BITS   = 20;
    localparam longint FX_ONE    = 64'sd1 << FRACTION_BITS;
    localparam int SETTLE_CYCLES = PIPE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [COLUMN_BITS-1:0] x;
        logic [COLUMN_BITS-1:0] z;
    } column_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_stall;
    logic [COLUMN_BITS-1:0] coord_x;
    logic [COLUMN_BITS-1:0] coord_z;
    logic                   out_valid;
    logic                   out_stall;
    logic [HEIGHT_W-1:0]    height;

    value_noise_terrain_height_unit #(
        .HEIGHT_CAP    (HEIGHT_CAP),
        .FRACTION_BITS (FRACTION_BITS),
        .COLUMN_BITS   (COLUMN_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coord_x   (coord_x),
        .coord_z   (coord_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .height    (height)
    );

    // predictor state and queues
    logic [63:0]         seed_model;
    column_t             column_queue[$];
    logic [HEIGHT_W-1:0] height_queue[$];
    int                  fail_count;
    int                  cycle_count;
    bit                  idle_off;
    bit                  hold_input;

    // floor division by 2^k on signed values
    function automatic longint floor_shr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_shr(longint v, int k);
        return floor_shr(v + (64'sd1 <<< (k - 1)), k);
    endfunction

    function automatic logic [31:0] mix_hash(logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * 32'h7feb352d;
        v = v ^ (v >> 15);
        v = v * 32'h846ca68b;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cz,
                                             logic [31:0] salt);
        logic [31:0] v;
        longint      h;
        v = cx * 32'h8da6b343;
        v = v ^ (cz * 32'hd8163841);
        v = v ^ seed_model[31:0];
        v = v ^ (seed_model[63:32] * 32'hcb1ab31f);
        v = v ^ salt;
        h = longint'(mix_hash(v) & 32'hffff);
        return (2 * (2 * h * FX_ONE) + 65535) / 131070 - FX_ONE;
    endfunction

    function automatic longint mix_lerp(longint a, longint b, longint w);
        return a + round_shr((b - a) * w, FRACTION_BITS);
    endfunction

    function automatic longint smooth_weight(longint rem, longint cells);
        longint t;
        longint t2;
        t  = (rem * 2 * FX_ONE + cells) / (2 * cells);
        t2 = round_shr(t * t, FRACTION_BITS);
        return round_shr(t2 * (3 * FX_ONE - 2 * t), FRACTION_BITS);
    endfunction

    function automatic longint noise_octave(logic [31:0] x, logic [31:0] z,
                                            logic [31:0] cells, logic [31:0] salt);
        logic [31:0] x0;
        logic [31:0] z0;
        longint      wx;
        longint      wz;
        longint      a;
        longint      b;
        x0 = x / cells;
        z0 = z / cells;
        wx = smooth_weight(longint'(x % cells), longint'(cells));
        wz = smooth_weight(longint'(z % cells), longint'(cells));
        a = mix_lerp(lattice_value(x0, z0, salt), lattice_value(x0 + 1, z0, salt), wx);
        b = mix_lerp(lattice_value(x0, z0 + 1, salt),
                     lattice_value(x0 + 1, z0 + 1, salt), wx);
        return mix_lerp(a, b, wz);
    endfunction

    function automatic logic [HEIGHT_W-1:0] predict_height(column_t c);
        logic [31:0] x;
        logic [31:0] z;
        longint      hi;
        longint      lo;
        longint      h;
        longint      p;
        longint      w;
        longint      q;
        x  = 32'(c.x);
        z  = 32'(c.z);
        hi = (68 * FX_ONE + 50) / 100;
        lo = -((72 * FX_ONE + 50) / 100);
        h  = 12 * FX_ONE;
        h += noise_octave(x, z, 48, SALT_CELL48) * 8;
        h += noise_octave(x, z, 18, SALT_CELL18) * 4;
        h += round_shr(noise_octave(x, z, 7, SALT_CELL7) * 3, 1);
        p = noise_octave(x, z, 64, SALT_CELL64);
        // plateau and basin pull
        if (p > hi)
        begin
            w = round_shr((p - hi) * 5, 1);
            if (w > FX_ONE)
                w = FX_ONE;
            h = mix_lerp(h, 22 * FX_ONE, w);
        end
        else if (p < lo)
        begin
            w = (lo - p) * 2;
            if (w > FX_ONE)
                w = FX_ONE;
            h = mix_lerp(h, 5 * FX_ONE, w);
        end
        q = floor_shr(h + FX_ONE / 2, FRACTION_BITS);
        if (q > HEIGHT_CAP)
            q = HEIGHT_CAP;
        if (q < 2)
            q = 2;
        return HEIGHT_W'(q);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // input driver: one transfer per accepted column
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            coord_x  <= '0;
            coord_z  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                height_queue.insert(height_queue.size(),
                                    predict_height({coord_x, coord_z}));
            if (column_queue.size() > 0 && !hold_input &&
                (idle_off || $urandom_range(99) >= 8))
            begin
                column_t c;
                c = column_queue.pop_front();
                in_valid <= 1'b1;
                coord_x  <= c.x;
                coord_z  <= c.z;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output stall and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (height_queue.size() == 0)
                    report_mismatch($sformatf("unexpected height %0d", height));
                else
                begin
                    logic [HEIGHT_W-1:0] want;
                    want = height_queue.pop_front();
                    if (height !== want)
                        report_mismatch($sformatf("height %0d expected %0d", height, want));
                end
            end
            out_stall <= idle_off ? 1'b0 : ($urandom_range(99) < 8);
        end
    end

    task automatic write_seed(logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        seed_model = value;
    endtask

    // wait until the pipeline has drained
    task automatic drain_pipeline();
        while (column_queue.size() > 0 || in_valid || height_queue.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_column(column_t c);
        column_queue.insert(column_queue.size(), c);
    endtask

    function automatic column_t random_column();
        column_t c;
        case ($urandom_range(5))
            0: c.x = COLUMN_BITS'($urandom_range(200));
            1: c.x = COLUMN_BITS'((1 << COLUMN_BITS) - 1 - $urandom_range(200));
            default: c.x = COLUMN_BITS'($urandom);
        endcase
        case ($urandom_range(5))
            0: c.z = COLUMN_BITS'($urandom_range(200));
            1: c.z = COLUMN_BITS'((1 << COLUMN_BITS) - 1 - $urandom_range(200));
            default: c.z = COLUMN_BITS'($urandom);
        endcase
        return c;
    endfunction

    initial
    begin
        logic [63:0] seeds[6];
        column_t     c;
        fail_count  = 0;
        cycle_count = 0;
        seed_model  = '0;
        idle_off    = 1'b0;
        hold_input  = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        rst_n   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, cell edges, all-ones coordinates, reset seed
        foreach (seeds[i])
            seeds[i] = '0;
        c.x = '0;   c.z = '0;   queue_column(c);
        c.x = '1;   c.z = '1;   queue_column(c);
        c.x = '1;   c.z = '0;   queue_column(c);
        c.x = '0;   c.z = '1;   queue_column(c);
        c.x = COLUMN_BITS'(47); c.z = COLUMN_BITS'(48); queue_column(c);
        c.x = COLUMN_BITS'(17); c.z = COLUMN_BITS'(18); queue_column(c);
        c.x = COLUMN_BITS'(6);  c.z = COLUMN_BITS'(7);  queue_column(c);
        c.x = COLUMN_BITS'(63); c.z = COLUMN_BITS'(64); queue_column(c);
        c.x = 20'h55555; c.z = 20'haaaaa; queue_column(c);
        c.x = 20'haaaaa; c.z = 20'h55555; queue_column(c);
        for (int i = 0; i < 10; i++)
        begin
            c.x = COLUMN_BITS'(1000 + 9 * i);
            c.z = COLUMN_BITS'(5000 + 13 * i);
            queue_column(c);
        end
        drain_pipeline();

        // seed phases, extremes among them
        seeds[0] = 64'hffff_ffff_ffff_ffff;
        seeds[1] = 64'h0000_0000_ffff_ffff;
        seeds[2] = 64'hffff_ffff_0000_0000;
        seeds[3] = {$urandom, $urandom};
        seeds[4] = {$urandom, $urandom};
        seeds[5] = '0;
        foreach (seeds[i])
        begin
            write_seed(seeds[i]);
            idle_off = (i == 2);
            for (int n = 0; n < 305; n++)
            begin
                // runs of neighbouring columns sweep across cell interiors
                if (n % 40 == 20)
                begin
                    c = random_column();
                    for (int k = 0; k < 16 && n < 305; k++, n++)
                    begin
                        queue_column(c);
                        c.x = c.x + 1'b1;
                    end
                end
                queue_column(random_column());
                if (n == 120 && i == 3)
                begin
                    // pause the sender until every height has come back
                    while (column_queue.size() > 0)
                        @(posedge clk);
                    hold_input = 1'b1;
                    while (in_valid || height_queue.size() > 0)
                        @(posedge clk);
                    hold_input = 1'b0;
                end
            end
            drain_pipeline();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
